@@ design/itoa_pkg.sv @@
// shared constants and controller/datapath command and status types
// for the signed integer to decimal text converter; no dependencies
package itoa_pkg;

	localparam int MAX_DIGITS = 10;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int DIV10_SHIFT = 35;

	typedef struct packed {
		logic load;
		logic conv;
		logic pop;
		logic sel_sign;
	} dp_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic neg;
		logic last_digit;
	} dp_sts_t;

endpackage

@@ design/itoa_if.sv @@
// input and output channel interfaces of the converter
// depends on nothing but the widths of the fields
interface itoa_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface itoa_out_if;
	logic valid;
	logic ready;
	logic [7:0] char_code;
	logic is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink (input valid, input char_code, input is_last, output ready);
endinterface

@@ design/itoa_dp.sv @@
// datapath: magnitude register, divide-by-ten step, digit buffer, char select
// depends on itoa_pkg
module itoa_dp (
	input logic clk,
	input itoa_pkg::dp_cmd_t cmd,
	output itoa_pkg::dp_sts_t sts,
	input logic signed [31:0] value,
	output logic [7:0] char_code,
	output logic is_last
);

	logic [31:0] mag_q;
	logic neg_q;
	logic [itoa_pkg::CNT_W-1:0] ndig_q;
	logic [itoa_pkg::IDX_W-1:0] rd_idx_q;
	logic [3:0] digit_q [itoa_pkg::MAX_DIGITS];

	logic [63:0] prod;
	logic [31:0] quot;
	logic [31:0] quot10;
	logic [31:0] rem_full;
	logic [3:0] rem;

	// quotient by reciprocal multiply, remainder by shift-add back
	assign prod = {32'd0, mag_q} * {32'd0, itoa_pkg::DIV10_RECIP};
	assign quot = {{itoa_pkg::DIV10_SHIFT - 32{1'b0}}, prod[63:itoa_pkg::DIV10_SHIFT]};
	assign quot10 = (quot << 3) + (quot << 1);
	assign rem_full = mag_q - quot10;
	assign rem = rem_full[3:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[31];
			mag_q <= value[31] ? (32'd0 - 32'(value)) : 32'(value);
			ndig_q <= '0;
		end else if (cmd.conv) begin
			digit_q[ndig_q[itoa_pkg::IDX_W-1:0]] <= rem;
			ndig_q <= ndig_q + 1'b1;
			rd_idx_q <= ndig_q[itoa_pkg::IDX_W-1:0];
			mag_q <= quot;
		end else if (cmd.pop) begin
			rd_idx_q <= rd_idx_q - 1'b1;
		end
	end

	assign sts.conv_done = (quot == 32'd0) ||
		(ndig_q == itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS - 1));
	assign sts.neg = neg_q;
	assign sts.last_digit = (rd_idx_q == '0);

	always_comb begin
		if (cmd.sel_sign) begin
			char_code = itoa_pkg::CHAR_MINUS;
			is_last = 1'b0;
		end else begin
			char_code = itoa_pkg::CHAR_ZERO + {4'd0, digit_q[rd_idx_q]};
			is_last = (rd_idx_q == '0);
		end
	end

endmodule

@@ design/itoa_ctrl.sv @@
// controller: sequences load, conversion steps and character beats
// depends on itoa_pkg
module itoa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output itoa_pkg::dp_cmd_t cmd,
	input itoa_pkg::dp_sts_t sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_SIGN = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_CONV;
				end
			end
			S_CONV: begin
				cmd.conv = 1'b1;
				if (sts.conv_done) begin
					state_nx = sts.neg ? S_SIGN : S_EMIT;
				end
			end
			S_SIGN: begin
				out_valid = 1'b1;
				cmd.sel_sign = 1'b1;
				if (out_ready) begin
					state_nx = S_EMIT;
				end
			end
			S_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.last_digit) begin
						state_nx = S_IDLE;
					end else begin
						cmd.pop = 1'b1;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// signed 32-bit integer to decimal ascii text, one character per output beat
// input beat, then one divide-by-ten step per digit (1 to 10 steps), then the
// optional minus sign and the digits, most significant first; characters leave
// one per cycle while dout.ready is high; one number at a time, a new input is
// taken only after the last character has left; single divide-by-ten multiplier
// reset: arst_n clears the controller to idle; datapath registers are not reset
module signed_int_to_decimal_ascii (
	input logic clk,
	input logic arst_n,
	itoa_in_if.sink din,
	itoa_out_if.source dout
);

	itoa_pkg::dp_cmd_t cmd;
	itoa_pkg::dp_sts_t sts;

	itoa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(din.valid),
		.in_ready(din.ready),
		.out_valid(dout.valid),
		.out_ready(dout.ready),
		.cmd(cmd),
		.sts(sts)
	);

	itoa_dp u_dp (
		.clk(clk),
		.cmd(cmd),
		.sts(sts),
		.value(din.value),
		.char_code(dout.char_code),
		.is_last(dout.is_last)
	);

endmodule
